// ===== rtl/siwg_pkg.sv =====
// ---------------------------------------------------------------------------
// siwg_pkg: shared types and constants for the status indicator watchdog gate
// Mode codes, register indexes, field widths and register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package siwg_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned AliveW   = 32;
  localparam int unsigned TickW    = 32;
  localparam int unsigned PatternW = 10;
  localparam int unsigned RepeatW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OwedW    = 2;
  // slot index as seen by the pattern lookup, covers up to 16 slots
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned SlotMax  = 16;

  typedef logic [ModeW-1:0] mode_t;

  localparam mode_t ModeDisabled = 2'd0;
  localparam mode_t ModeTeleop   = 2'd1;
  localparam mode_t ModeAuto     = 2'd2;
  localparam mode_t ModeFault    = 2'd3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegLinkTimeout = 3'd0;
  localparam cfg_idx_t RegPatDisabled = 3'd1;
  localparam cfg_idx_t RegPatTeleop   = 3'd2;
  localparam cfg_idx_t RegPatAuto     = 3'd3;
  localparam cfg_idx_t RegPatFault    = 3'd4;
  localparam cfg_idx_t RegFaultRepeat = 3'd5;

  localparam logic [AgeW-1:0]     LinkTimeoutRst = 32'd250;
  localparam logic [PatternW-1:0] PatDisabledRst = 10'b0000011111;
  localparam logic [PatternW-1:0] PatTeleopRst   = 10'b0101010101;
  localparam logic [PatternW-1:0] PatAutoRst     = 10'b0000000101;
  localparam logic [PatternW-1:0] PatFaultRst    = 10'b1111111111;
  localparam logic [RepeatW-1:0]  FaultRepeatRst = 8'd10;

  localparam logic [OwedW-1:0] ChirpsOnEnable  = 2'd1;
  localparam logic [OwedW-1:0] ChirpsOnDisable = 2'd2;
  localparam logic [OwedW-1:0] ChirpsOnFault   = 2'd2;

endpackage : siwg_pkg

`default_nettype wire

// ===== rtl/siwg_if.sv =====
// ---------------------------------------------------------------------------
// siwg_in_if / siwg_out_if: valid/ready channels of the indicator gate
// Tick snapshot requests in, LED/chirp/refresh results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface siwg_in_if;
  logic                           valid;
  logic                           ready;
  logic [siwg_pkg::ModeW-1:0]     mode;
  logic [siwg_pkg::AgeW-1:0]      link_age_ms;
  logic                           fault_held;
  logic [siwg_pkg::AliveW-1:0]    alive_count;

  modport source (output valid, mode, link_age_ms, fault_held, alive_count, input ready);
  modport sink   (input valid, mode, link_age_ms, fault_held, alive_count, output ready);
endinterface : siwg_in_if

interface siwg_out_if;
  logic valid;
  logic ready;
  logic led_mode_on;
  logic led_link_on;
  logic led_fault_on;
  logic chirp_now;
  logic refresh_watchdog;

  modport source (output valid, led_mode_on, led_link_on, led_fault_on, chirp_now,
                  refresh_watchdog, input ready);
  modport sink   (input valid, led_mode_on, led_link_on, led_fault_on, chirp_now,
                  refresh_watchdog, output ready);
endinterface : siwg_out_if

`default_nettype wire

// ===== rtl/status_indicator_watchdog_gate_core.sv =====
// ---------------------------------------------------------------------------
// status_indicator_watchdog_gate_core: heartbeat LED, chirp and watchdog gate
// A request accepted at one edge has its result registered at that edge.
// Throughput 1 request per cycle, set by the single result
// register, which frees whenever the downstream side takes it.
// Reset (async, active low) clears tick, slot, chirp queue and liveness state
// and loads the default timeout, blink masks and fault repeat period.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module status_indicator_watchdog_gate_core #(
  parameter int unsigned BLINK_SLOTS = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [siwg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [siwg_pkg::CfgDataW-1:0]    cfg_wdata_i,
  siwg_in_if.sink                               req_i,
  siwg_out_if.source                            rsp_o
);

  localparam int unsigned SlotW = (BLINK_SLOTS > 1) ? $clog2(BLINK_SLOTS) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(BLINK_SLOTS - 1);

  // configuration
  logic [siwg_pkg::AgeW-1:0]     link_timeout_q;
  logic [siwg_pkg::PatternW-1:0] pat_disabled_q, pat_teleop_q, pat_auto_q, pat_fault_q;
  logic [siwg_pkg::RepeatW-1:0]  fault_repeat_q;

  // tick state
  logic [siwg_pkg::TickW-1:0]    tick_q, tick_d;
  logic [SlotW-1:0]              slot_q, slot_d;
  siwg_pkg::mode_t               prev_mode_q, prev_mode_d;
  logic [siwg_pkg::OwedW-1:0]    owed_q, owed_d, owed_set;
  logic [siwg_pkg::TickW-1:0]    fault_tick_q, fault_tick_d;
  logic [siwg_pkg::AliveW-1:0]   last_alive_q, last_alive_d;

  // result register
  logic out_valid_q;
  logic led_mode_q, led_link_q, led_fault_q, chirp_q, refresh_q;
  logic led_mode_d, led_link_d, chirp_d, refresh_d;

  logic                             accept;
  logic [siwg_pkg::PatternW-1:0]    pattern;
  logic [siwg_pkg::SlotMax-1:0]     pattern_ext;
  logic [siwg_pkg::SlotIdxW-1:0]    slot_ext;
  logic [siwg_pkg::TickW-1:0]       since_fault;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_timeout_q <= siwg_pkg::LinkTimeoutRst;
      pat_disabled_q <= siwg_pkg::PatDisabledRst;
      pat_teleop_q   <= siwg_pkg::PatTeleopRst;
      pat_auto_q     <= siwg_pkg::PatAutoRst;
      pat_fault_q    <= siwg_pkg::PatFaultRst;
      fault_repeat_q <= siwg_pkg::FaultRepeatRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        siwg_pkg::RegLinkTimeout: link_timeout_q <= cfg_wdata_i;
        siwg_pkg::RegPatDisabled: pat_disabled_q <= cfg_wdata_i[siwg_pkg::PatternW-1:0];
        siwg_pkg::RegPatTeleop:   pat_teleop_q   <= cfg_wdata_i[siwg_pkg::PatternW-1:0];
        siwg_pkg::RegPatAuto:     pat_auto_q     <= cfg_wdata_i[siwg_pkg::PatternW-1:0];
        siwg_pkg::RegPatFault:    pat_fault_q    <= cfg_wdata_i[siwg_pkg::PatternW-1:0];
        siwg_pkg::RegFaultRepeat: fault_repeat_q <= cfg_wdata_i[siwg_pkg::RepeatW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (req_i.mode)
      siwg_pkg::ModeTeleop: pattern = pat_teleop_q;
      siwg_pkg::ModeAuto:   pattern = pat_auto_q;
      siwg_pkg::ModeFault:  pattern = pat_fault_q;
      default:              pattern = pat_disabled_q;
    endcase
  end

  // slots past the mask width read dark
  assign pattern_ext = siwg_pkg::SlotMax'(pattern);
  assign slot_ext    = siwg_pkg::SlotIdxW'(slot_q);
  assign led_mode_d  = pattern_ext[slot_ext];
  assign led_link_d  = req_i.link_age_ms < link_timeout_q;

  assign refresh_d    = req_i.alive_count != last_alive_q;
  assign last_alive_d = refresh_d ? req_i.alive_count : last_alive_q;

  assign since_fault = tick_q - fault_tick_q;

  always_comb begin
    owed_set     = owed_q;
    fault_tick_d = fault_tick_q;
    prev_mode_d  = prev_mode_q;
    if (req_i.mode != prev_mode_q) begin
      prev_mode_d = req_i.mode;
      unique case (req_i.mode)
        siwg_pkg::ModeFault: begin
          owed_set     = siwg_pkg::ChirpsOnFault;
          fault_tick_d = tick_q;
        end
        siwg_pkg::ModeTeleop, siwg_pkg::ModeAuto: owed_set = siwg_pkg::ChirpsOnEnable;
        default: owed_set = siwg_pkg::ChirpsOnDisable;
      endcase
    end else if (req_i.mode == siwg_pkg::ModeFault &&
                 since_fault >= siwg_pkg::TickW'(fault_repeat_q)) begin
      owed_set     = siwg_pkg::ChirpsOnFault;
      fault_tick_d = tick_q;
    end
    // one chirp per tick at most
    chirp_d = owed_set != '0;
    owed_d  = chirp_d ? owed_set - 1'b1 : owed_set;
  end

  assign tick_d = tick_q + 1'b1;
  assign slot_d = (slot_q == SlotLast) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      slot_q       <= '0;
      prev_mode_q  <= siwg_pkg::ModeDisabled;
      owed_q       <= '0;
      fault_tick_q <= '0;
      last_alive_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        tick_q       <= tick_d;
        slot_q       <= slot_d;
        prev_mode_q  <= prev_mode_d;
        owed_q       <= owed_d;
        fault_tick_q <= fault_tick_d;
        last_alive_q <= last_alive_d;
        out_valid_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      led_mode_q  <= led_mode_d;
      led_link_q  <= led_link_d;
      led_fault_q <= req_i.fault_held;
      chirp_q     <= chirp_d;
      refresh_q   <= refresh_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.led_mode_on      = led_mode_q;
  assign rsp_o.led_link_on      = led_link_q;
  assign rsp_o.led_fault_on     = led_fault_q;
  assign rsp_o.chirp_now        = chirp_q;
  assign rsp_o.refresh_watchdog = refresh_q;

endmodule : status_indicator_watchdog_gate_core

`default_nettype wire
